// ===== src/serial_keypad_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver assertion macros
// Concurrent check wrappers clocked on clk; NO_ASSERTIONS strips them out.
// ----------------------------------------------------------------------------
`ifndef SERIAL_KEYPAD_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_KEYPAD_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define SKPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check at every edge, reset included
`define SKPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SKPR_ASSERT(label, prop, msg)
`define SKPR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/skpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver package
// Shared types, phase constants and the pin table of the frame sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package skpr_pkg;

    localparam int PHASE_W = 5;
    localparam logic [PHASE_W-1:0] PHASE_COUNT = 5'd26;
    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 5'd31;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 5'd0;
    localparam logic [PHASE_W-1:0] DATA_FIRST  = 5'd6;
    localparam logic [PHASE_W-1:0] DATA_LAST   = 5'd20;

    localparam int HALF_PERIOD_W = 16;
    localparam int COLUMNS_W     = 5;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd25;
    localparam logic [COLUMNS_W-1:0]     KEY_COLUMNS_RESET = 5'd8;
    localparam logic [COLUMNS_W-1:0]     MAX_COLUMNS       = 5'd16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_KEY_COLUMNS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic scl;
        logic sda_low;
    } pins_t;

    // per-tick result of the sequencer
    typedef struct packed {
        pins_t      pins;
        logic       busy;
        logic       done;
        logic [7:0] byte_val;
    } step_res_t;

    typedef struct packed {
        logic       pressed;
        logic [2:0] row;
        logic [3:0] column;
        logic [6:0] index;
        logic [7:0] raw;
    } key_event_t;

    // pin levels for a phase; anything past the frame is the idle bus
    function automatic pins_t phase_pins(input logic [PHASE_W-1:0] ph);
        pins_t p;
        p = '{scl: 1'b1, sda_low: 1'b0};
        case (ph) inside
            [5'd0:5'd2]:   p = '{scl: 1'b1, sda_low: 1'b1};
            5'd3:          p = '{scl: 1'b0, sda_low: 1'b1};
            5'd4:          p = '{scl: 1'b0, sda_low: 1'b0};
            5'd5:          p = '{scl: 1'b1, sda_low: 1'b0};
            [5'd6:5'd21]:  p = '{scl: ph[0], sda_low: 1'b0};
            [5'd22:5'd23]: p = '{scl: 1'b1, sda_low: 1'b1};
            5'd24:         p = '{scl: 1'b0, sda_low: 1'b1};
            5'd25:         p = '{scl: 1'b1, sda_low: 1'b0};
            default:       p = '{scl: 1'b1, sda_low: 1'b0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/skpr_in_if.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver sample channel
// Valid/ready channel carrying the sampled IRQ and SDA levels of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface skpr_in_if;
    logic valid;
    logic ready;
    logic irq_level;
    logic sda_level;

    modport source (output valid, output irq_level, output sda_level, input ready);
    modport sink   (input valid, input irq_level, input sda_level, output ready);
endinterface

`default_nettype wire

// ===== src/skpr_out_if.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver report channel
// Valid/ready channel carrying pin levels, status and the decoded key event.
// ----------------------------------------------------------------------------
`default_nettype none

interface skpr_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive_low;
    logic       busy_res;
    logic       event_valid;
    logic       key_pressed;
    logic [2:0] key_row;
    logic [3:0] key_column;
    logic [6:0] key_index;
    logic [7:0] raw_byte;

    modport source (
        output valid, output scl_level, output sda_drive_low, output busy_res,
        output event_valid, output key_pressed, output key_row, output key_column,
        output key_index, output raw_byte, input ready
    );
    modport sink (
        input valid, input scl_level, input sda_drive_low, input busy_res,
        input event_valid, input key_pressed, input key_row, input key_column,
        input key_index, input raw_byte, output ready
    );
endinterface

`default_nettype wire

// ===== src/skpr_step.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame sequencer
// Edge detect, phase counter, phase timer and data shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module skpr_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  advance,
    input  wire                                  irq_level,
    input  wire                                  sda_level,
    input  wire  [skpr_pkg::HALF_PERIOD_W-1:0]   half_period,
    output skpr_pkg::step_res_t                  res
);
    import skpr_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > HALF_PERIOD_W) ? TIMER_WIDTH : HALF_PERIOD_W;

    logic                   irq_prev_reg, irq_prev_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [7:0]             shift_reg, shift_next;

    logic [CMP_W-1:0]       hp_w, tmax_w, lim_w;
    logic [TIMER_WIDTH-1:0] limit;
    logic                   fall;
    logic                   done;

    // phase length: zero acts as one, saturate to the timer range
    always_comb
    begin
        hp_w   = CMP_W'(half_period);
        tmax_w = CMP_W'({TIMER_WIDTH{1'b1}});
        if (hp_w == '0)
            lim_w = CMP_W'(1);
        else if (hp_w > tmax_w)
            lim_w = tmax_w;
        else
            lim_w = hp_w;
        limit = lim_w[TIMER_WIDTH-1:0];
    end

    assign fall = irq_prev_reg & ~irq_level;

    always_comb
    begin
        irq_prev_next = irq_level;
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        shift_next    = shift_reg;
        done          = 1'b0;
        if (phase_reg >= PHASE_COUNT) begin
            phase_next = PHASE_IDLE;
            if (fall) begin
                phase_next = PHASE_FIRST;
                timer_next = TIMER_WIDTH'(1);
                shift_next = '0;
            end
        end else if (timer_reg >= limit) begin
            // sample SDA at the end of each data-bit low phase
            if ((phase_reg inside {[DATA_FIRST:DATA_LAST]}) && !phase_reg[0])
                shift_next = {shift_reg[6:0], sda_level};
            timer_next = TIMER_WIDTH'(1);
            if (phase_reg + PHASE_W'(1) >= PHASE_COUNT) begin
                phase_next = PHASE_IDLE;
                timer_next = '0;
                done       = 1'b1;
            end else begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end else begin
            timer_next = timer_reg + TIMER_WIDTH'(1);
        end
    end

    always_comb
    begin
        res.pins     = phase_pins(phase_next);
        res.busy     = (phase_next < PHASE_COUNT);
        res.done     = done;
        res.byte_val = shift_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            irq_prev_reg <= 1'b1;
            phase_reg    <= PHASE_IDLE;
            timer_reg    <= '0;
            shift_reg    <= '0;
        end else if (advance) begin
            irq_prev_reg <= irq_prev_next;
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/skpr_decode.sv =====
// ----------------------------------------------------------------------------
// Serial keypad byte decoder
// Splits the received byte into press flag, row and column, forms key index.
// ----------------------------------------------------------------------------
`default_nettype none

module skpr_decode (
    input  wire                                 done,
    input  wire  [7:0]                          byte_val,
    input  wire  [skpr_pkg::COLUMNS_W-1:0]      key_columns,
    output skpr_pkg::key_event_t                key_event
);
    import skpr_pkg::*;

    logic [COLUMNS_W-1:0] cols;
    logic [3:0]           col;
    logic [2:0]           row;
    logic [7:0]           index_w;

    always_comb
    begin
        cols    = (key_columns > MAX_COLUMNS) ? MAX_COLUMNS : key_columns;
        row     = byte_val[6:4];
        col     = (byte_val[3:0] != 4'd0) ? (byte_val[3:0] - 4'd1) : 4'd0;
        // widen both factors first: row 7 by sixteen columns needs seven bits
        index_w = 8'(row) * 8'(cols) + 8'(col);

        key_event = '0;
        if (done) begin
            key_event.pressed = ~byte_val[7];
            key_event.row     = row;
            key_event.column  = col;
            key_event.index   = index_w[6:0];
            key_event.raw     = byte_val;
        end
    end

endmodule

`default_nettype wire

// ===== src/serial_keypad_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver
// Clocks one byte out of a keypad controller after an IRQ fall and reports it.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake           Carries
//   sample    in    valid/ready         irq_level, sda_level (one tick)
//   report    out   valid/ready         pins, busy, key event (one per tick)
//   cfg       in    cfg_we, no stall    half_period_ticks, key_columns
//
// One request is taken every cycle while sample.ready is high; each request
// gives one report, passing the sample register and then the report register.
// Reset clears the sequencer to idle with SCL high and SDA released, and
// loads half_period_ticks = 25, key_columns = 8.
// A stalled report holds its register; the sample register keeps one more
// request, and sample.ready drops only once both are full.
//
`default_nettype none

`include "serial_keypad_frame_receiver_assert.svh"

module serial_keypad_frame_receiver #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    skpr_in_if.sink                            sample,
    skpr_out_if.source                         report,
    input  wire                                cfg_we,
    input  wire  [skpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [skpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import skpr_pkg::*;

    // configuration
    logic [HALF_PERIOD_W-1:0] half_period_reg;
    logic [COLUMNS_W-1:0]     key_columns_reg;

    // sample register
    logic s1_valid_reg, s1_valid_next;
    logic s1_irq_reg;
    logic s1_sda_reg;

    // report register
    logic        out_valid_reg, out_valid_next;
    step_res_t   out_step_reg;
    key_event_t  out_event_reg;

    logic        advance;
    logic        take;
    step_res_t   step_res;
    key_event_t  key_event;

    // advance the sample into the report slot when that slot is free or leaving
    assign advance = s1_valid_reg && (!out_valid_reg || report.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_period_reg <= HALF_PERIOD_RESET;
            key_columns_reg <= KEY_COLUMNS_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_HALF_PERIOD: half_period_reg <= cfg_data[HALF_PERIOD_W-1:0];
                CFG_KEY_COLUMNS: key_columns_reg <= cfg_data[COLUMNS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (report.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the request payload
    always_ff @(posedge clk)
    begin
        if (take) begin
            s1_irq_reg <= sample.irq_level;
            s1_sda_reg <= sample.sda_level;
        end
    end

    skpr_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .irq_level   (s1_irq_reg),
        .sda_level   (s1_sda_reg),
        .half_period (half_period_reg),
        .res         (step_res)
    );

    skpr_decode u_decode (
        .done        (step_res.done),
        .byte_val    (step_res.byte_val),
        .key_columns (key_columns_reg),
        .key_event   (key_event)
    );

    // hold the report payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_step_reg  <= step_res;
            out_event_reg <= key_event;
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.scl_level     = out_step_reg.pins.scl;
    assign report.sda_drive_low = out_step_reg.pins.sda_low;
    assign report.busy_res      = out_step_reg.busy;
    assign report.event_valid   = out_step_reg.done;
    assign report.key_pressed   = out_event_reg.pressed;
    assign report.key_row       = out_event_reg.row;
    assign report.key_column    = out_event_reg.column;
    assign report.key_index     = out_event_reg.index;
    assign report.raw_byte      = out_event_reg.raw;

    // a key event is always shown on an idle bus
    `SKPR_ASSERT(a_event_idle_bus,
        (report.valid && report.event_valid) |->
        (!report.busy_res && report.scl_level && !report.sda_drive_low),
        "key event reported while the frame is still busy")

    // requests stop only when both registers hold unsent work
    `SKPR_ASSERT(a_ready_only_when_full,
        !sample.ready |-> (s1_valid_reg && out_valid_reg && !report.ready),
        "sample channel stalled with free room")

    // a stalled report keeps the sequencer frozen
    `SKPR_ASSERT(a_stall_freezes_step,
        (report.valid && !report.ready) |-> !advance,
        "sequencer advanced while report stalled")

    // busy reports never claim an event
    `SKPR_ASSERT_ALWAYS(a_busy_no_event,
        !rst_n || !(report.valid && report.busy_res && report.event_valid),
        "event flagged during a busy tick")

endmodule

`default_nettype wire

// ===== tb/tb_serial_keypad_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Serial keypad frame receiver testbench
// Streams tick requests of sampled IRQ/SDA levels through the sample channel
// and checks every report (pins, busy flag, decoded key event) against a
// tick-by-tick prediction of the frame sequencer, or a hand-typed report,
// across several register settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_serial_keypad_frame_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    import skpr_pkg::*;

    // Hard stop: far beyond the slowest correct run (a few hundred requests,
    // each waiting out long receiver stalls).
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int unsigned MAX_REPORTED = 20;

    // One report as seen on the report channel, field for field.
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_low;
        logic       busy_res;
        logic       event_valid;
        logic       key_pressed;
        logic [2:0] key_row;
        logic [3:0] key_column;
        logic [6:0] key_index;
        logic [7:0] raw_byte;
    } keypad_report_t;

    // One tick request; 'pinned' marks a report typed in by hand.
    typedef struct packed {
        logic           irq_level;
        logic           sda_level;
        logic           pinned;
        keypad_report_t want;
    } tick_request_t;

    // Row of the directed table: a request repeated 'reps' times.
    typedef struct packed {
        logic           irq_level;
        logic           sda_level;
        logic [7:0]     reps;
        logic           pinned;
        keypad_report_t want;
    } directed_row_t;

    // Bus idle: SCL high, SDA released, nothing else.
    localparam keypad_report_t BUS_IDLE = '{
        scl_level: 1'b1, sda_drive_low: 1'b0, busy_res: 1'b0, event_valid: 1'b0,
        key_pressed: 1'b0, key_row: 3'd0, key_column: 4'd0, key_index: 7'd0,
        raw_byte: 8'h00
    };

    // All-ones byte with sixteen columns: release, row 7, column 14, top index.
    localparam keypad_report_t ALL_ONES_EVENT = '{
        scl_level: 1'b1, sda_drive_low: 1'b0, busy_res: 1'b0, event_valid: 1'b1,
        key_pressed: 1'b0, key_row: 3'd7, key_column: 4'd14, key_index: 7'd126,
        raw_byte: 8'hFF
    };

    // Directed frame with a half period of one tick: the edge tick is tick 0
    // and the event lands on tick 26. SDA is held high, so the byte is 0xFF.
    localparam directed_row_t DIRECTED [10] = '{
        '{irq_level: 1'b1, sda_level: 1'b0, reps: 8'd1,  pinned: 1'b1, want: BUS_IDLE},
        '{irq_level: 1'b1, sda_level: 1'b1, reps: 8'd1,  pinned: 1'b1, want: BUS_IDLE},
        // falling edge while idle: frame starts on this tick
        '{irq_level: 1'b0, sda_level: 1'b1, reps: 8'd1,  pinned: 1'b0, want: BUS_IDLE},
        '{irq_level: 1'b1, sda_level: 1'b1, reps: 8'd5,  pinned: 1'b0, want: BUS_IDLE},
        // falling edge mid-frame: must be ignored
        '{irq_level: 1'b0, sda_level: 1'b1, reps: 8'd3,  pinned: 1'b0, want: BUS_IDLE},
        '{irq_level: 1'b1, sda_level: 1'b1, reps: 8'd17, pinned: 1'b0, want: BUS_IDLE},
        // completion tick carries a falling edge too: event, no new frame
        '{irq_level: 1'b0, sda_level: 1'b1, reps: 8'd1,  pinned: 1'b1,
          want: ALL_ONES_EVENT},
        '{irq_level: 1'b0, sda_level: 1'b0, reps: 8'd1,  pinned: 1'b1, want: BUS_IDLE},
        '{irq_level: 1'b1, sda_level: 1'b0, reps: 8'd1,  pinned: 1'b1, want: BUS_IDLE},
        '{irq_level: 1'b1, sda_level: 1'b1, reps: 8'd1,  pinned: 1'b1, want: BUS_IDLE}
    };

    // Bytes worth forcing now and then: zero nibble, sign bit, all ones...
    localparam logic [7:0] CORNER_BYTES [8] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0F, 8'h01, 8'h10, 8'hF1
    };

    // Pin levels per phase, bit n belongs to phase n.
    localparam logic [25:0] SCL_BY_PHASE     = 26'b1011_1010101010101010_100111;
    localparam logic [25:0] SDA_LOW_BY_PHASE = 26'b0111_0000000000000000_001111;

    logic clk = 1'b0;
    logic rst_n;

    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    skpr_in_if  sample_ch ();
    skpr_out_if report_ch ();

    serial_keypad_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .report    (report_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predicted sequencer state and its register copies
    // ------------------------------------------------------------------------
    logic                     irq_seen;
    logic [PHASE_W-1:0]       seq_phase;
    int unsigned              seq_timer;
    logic [7:0]               seq_shift;
    logic [HALF_PERIOD_W-1:0] half_period;
    logic [COLUMNS_W-1:0]     column_count;

    // ------------------------------------------------------------------------
    // Stimulus store, expectations and bookkeeping
    // ------------------------------------------------------------------------
    tick_request_t  tick_requests[$];
    keypad_report_t pending_reports[$];
    int             taken_count = 0;   // requests accepted so far
    int             offered_at  = -1;  // request currently on the channel
    logic           last_irq;          // level the generator ended on

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold_left = 0;

    int errors        = 0;
    int reports_seen  = 0;
    int presses_seen  = 0;
    int releases_seen = 0;
    int settings_run  = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: advance the sequencer one tick and form its report.
    // ------------------------------------------------------------------------
    function automatic keypad_report_t next_pin_report(input logic irq, input logic sda);
        keypad_report_t rep;
        logic           fall;
        logic           done;
        logic [7:0]     code;
        logic [3:0]     column;
        logic [2:0]     row;
        int unsigned    hold_ticks;
        int unsigned    cols;

        fall     = irq_seen && !irq;
        irq_seen = irq;
        done     = 1'b0;
        code     = 8'h00;
        // a zero half period behaves as one tick
        hold_ticks = (half_period == '0) ? 1 : half_period;

        if (seq_phase >= PHASE_COUNT)
        begin
            seq_phase = PHASE_IDLE;
            if (fall)
            begin
                seq_phase = PHASE_FIRST;
                seq_timer = 1;
                seq_shift = 8'h00;
            end
        end
        else if (seq_timer >= hold_ticks)
        begin
            // sample SDA on the last tick of each data SCL-low phase
            if (seq_phase >= DATA_FIRST && seq_phase <= DATA_LAST && !seq_phase[0])
                seq_shift = {seq_shift[6:0], sda};
            seq_phase = seq_phase + 1'b1;
            seq_timer = 1;
            if (seq_phase >= PHASE_COUNT)
            begin
                seq_phase = PHASE_IDLE;
                seq_timer = 0;
                done      = 1'b1;
                code      = seq_shift;
            end
        end
        else
            seq_timer++;

        rep = '0;
        if (seq_phase < PHASE_COUNT)
        begin
            rep.scl_level     = SCL_BY_PHASE[seq_phase];
            rep.sda_drive_low = SDA_LOW_BY_PHASE[seq_phase];
            rep.busy_res      = 1'b1;
        end
        else
            rep.scl_level = 1'b1;

        if (done)
        begin
            column = code[3:0];
            if (column != 4'd0)
                column = column - 4'd1;
            row  = code[6:4];
            cols = (column_count > MAX_COLUMNS) ? MAX_COLUMNS : column_count;
            rep.event_valid = 1'b1;
            rep.key_pressed = !code[7];
            rep.key_row     = row;
            rep.key_column  = column;
            rep.key_index   = 7'(row * cols + column);
            rep.raw_byte    = code;
        end
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: change inputs on the falling edge; hold a request until
    // it is taken, then offer the next one or leave a gap.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && offered_at == taken_count)
            begin
                // hold: the offered request has not been taken yet
            end
            else if (taken_count < tick_requests.size()
                     && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample_ch.valid     <= 1'b1;
                sample_ch.irq_level <= tick_requests[taken_count].irq_level;
                sample_ch.sda_level <= tick_requests[taken_count].sda_level;
                offered_at = taken_count;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Report receiver: a requested hold-off wins over the random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            report_ch.ready <= 1'b0;
        else if (recv_hold_left > 0)
        begin
            report_ch.ready <= 1'b0;
            recv_hold_left--;
        end
        else
            report_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every taken request, check every taken report.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        keypad_report_t predicted;
        keypad_report_t seen;
        keypad_report_t want;
        tick_request_t  req;

        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                req       = tick_requests[taken_count];
                // advance the prediction even where the report is typed in
                predicted = next_pin_report(sample_ch.irq_level, sample_ch.sda_level);
                pending_reports.push_back(req.pinned ? req.want : predicted);
                taken_count++;
            end

            if (report_ch.valid && report_ch.ready)
            begin
                seen = '{
                    scl_level:     report_ch.scl_level,
                    sda_drive_low: report_ch.sda_drive_low,
                    busy_res:      report_ch.busy_res,
                    event_valid:   report_ch.event_valid,
                    key_pressed:   report_ch.key_pressed,
                    key_row:       report_ch.key_row,
                    key_column:    report_ch.key_column,
                    key_index:     report_ch.key_index,
                    raw_byte:      report_ch.raw_byte
                };
                reports_seen++;
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTED)
                        $display("%0t: report with nothing pending: %p", $realtime, seen);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTED)
                            $display("%0t: report %0d mismatch\n  expected %p\n  actual   %p",
                                     $realtime, reports_seen, want, seen);
                    end
                    else if (want.event_valid)
                    begin
                        if (want.key_pressed)
                            presses_seen++;
                        else
                            releases_seen++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic add_tick(input logic irq, input logic sda);
        tick_request_t req;
        req = '{irq_level: irq, sda_level: sda, pinned: 1'b0, want: BUS_IDLE};
        tick_requests.push_back(req);
        last_irq = irq;
    endtask

    // Idle noise: once the line is high keep it high, so no frame starts.
    task automatic add_idle(input int unsigned count);
        repeat (count)
            add_tick(last_irq ? 1'b1 : 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // One well-formed frame: an edge, then 26 phases of 'ticks' each with IRQ
    // noise throughout and the chosen byte on the SDA sampling ticks.
    task automatic add_frame(input int unsigned ticks);
        logic [7:0]  code;
        logic        end_fall;
        logic        irq;
        logic        sda;
        int unsigned span;
        int unsigned slot;

        if ($urandom_range(0, 2) == 0)
            code = CORNER_BYTES[$urandom_range(0, 7)];
        else
            code = 8'($urandom);
        end_fall = ($urandom_range(0, 2) == 0);
        span     = 26 * ticks;

        if (!last_irq)
            add_tick(1'b1, 1'($urandom_range(0, 1)));
        add_tick(1'b0, 1'($urandom_range(0, 1)));
        for (int unsigned t = 1; t <= span; t++)
        begin
            irq = 1'($urandom_range(0, 1));
            sda = 1'($urandom_range(0, 1));
            // drop the line exactly on the completion tick now and then
            if (end_fall && t == span - 1)
                irq = 1'b1;
            if (end_fall && t == span)
                irq = 1'b0;
            slot = t / ticks;
            if (t % ticks == 0 && slot >= 7 && slot <= 21 && slot % 2 == 1)
                sda = code[7 - (slot - 7) / 2];
            add_tick(irq, sda);
        end
    endtask

    task automatic load_directed();
        tick_request_t req;
        foreach (DIRECTED[r])
        begin
            req = '{irq_level: DIRECTED[r].irq_level, sda_level: DIRECTED[r].sda_level,
                    pinned: DIRECTED[r].pinned, want: DIRECTED[r].want};
            repeat (DIRECTED[r].reps)
                tick_requests.push_back(req);
            last_irq = DIRECTED[r].irq_level;
        end
    endtask

    // Register write on the plain port; the block is idle whenever this runs.
    task automatic write_reg(input cfg_index_t which, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        if (which == CFG_HALF_PERIOD)
            half_period = value[HALF_PERIOD_W-1:0];
        else
            column_count = value[COLUMNS_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every report has come back.
    task automatic drain();
        while (taken_count < tick_requests.size() || pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // One register setting: write both registers, then either frames with
    // idle noise between them up to the budget, or idle ticks only.
    task automatic run_setting(input logic [CFG_DATA_W-1:0] half,
                               input logic [CFG_DATA_W-1:0] cols_word,
                               input int unsigned budget, input logic frames,
                               input int unsigned hold_off);
        int unsigned start;
        int unsigned ticks;
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_KEY_COLUMNS, cols_word);
        @(posedge clk);
        start = tick_requests.size();
        ticks = (half == '0) ? 1 : half;
        if (frames)
        begin
            while (tick_requests.size() - start < budget)
            begin
                add_idle($urandom_range(0, 3));
                add_frame(ticks);
            end
            add_idle(2);
        end
        else
            add_idle(budget);
        recv_hold_left = hold_off;
        settings_run++;
        drain();
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_HALF_PERIOD;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.irq_level = 1'b1;
        sample_ch.sda_level = 1'b0;
        report_ch.ready     = 1'b0;

        // predicted state after reset
        irq_seen     = 1'b1;
        seq_phase    = PHASE_IDLE;
        seq_timer    = 0;
        seq_shift    = 8'h00;
        half_period  = HALF_PERIOD_RESET;
        column_count = KEY_COLUMNS_RESET;
        last_irq     = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender nearly always busy, receiver mostly stalled
        set_idling(6, 81);
        write_reg(CFG_HALF_PERIOD, 16'd0);   // zero acts as one tick
        write_reg(CFG_KEY_COLUMNS, 16'd16);
        @(posedge clk);
        load_directed();
        settings_run++;
        drain();

        // long receiver hold-off while requests keep coming: input must stall
        run_setting(16'd1, 16'd8, 25, 1'b1, 80);
        run_setting(16'd2, 16'h05A0, 25, 1'b1, 0);   // column count zero

        // the other way round: sender sparse, receiver eager
        set_idling(81, 6);
        run_setting(16'd1, 16'hFFFF, 25, 1'b1, 0);   // 31 columns saturate to 16
        run_setting(16'd3, 16'd1, 25, 1'b1, 0);
        // longest half period: a frame would take far too long, so idle only
        run_setting(16'hFFFF, 16'd17, 30, 1'b0, 0);

        // no idling on either side
        set_idling(0, 0);
        run_setting(16'd1, 16'd16, 25, 1'b1, 0);
        run_setting(16'($urandom_range(1, 4)), 16'($urandom), 25, 1'b1, 0);
        run_setting(16'd0, 16'($urandom), 25, 1'b1, 0);

        drain();
        repeat (10) @(posedge clk);

        $display("Ran %0d tick requests over %0d register settings, %0d reports checked.",
                 taken_count, settings_run, reports_seen);
        $display("Key events decoded: %0d presses, %0d releases; %0d mismatches.",
                 presses_seen, releases_seen, errors);
        if (errors == 0 && pending_reports.size() == 0)
            $display("PASS serial_keypad_frame_receiver");
        else
            $display("FAIL serial_keypad_frame_receiver");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(RUN_LIMIT_NS * 1ns);
        $display("Timed out with %0d reports still pending.", pending_reports.size());
        $display("FAIL serial_keypad_frame_receiver");
        $finish;
    end

endmodule
